### hw/rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// widths, constants and request types for the quaternion vector rotator
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    // quaternion fraction bits, the vector keeps its own scale through the datapath
    localparam int ROT_FRAC_BITS = 14;

    localparam int VEC_W     = 32;
    localparam int ROT_W     = 16;
    localparam int PROD1_W   = VEC_W + ROT_W;        // q * v
    localparam int U_W       = PROD1_W + 1;          // q.xyz x v
    localparam int PROD2_W   = U_W + ROT_W;          // q * uv
    localparam int W_W       = PROD2_W + 1;          // q.xyz x uv
    localparam int ACC_W     = W_W + 2;              // v + 2*w*uv + 2*uuv
    localparam int RND_SHIFT = 2 * ROT_FRAC_BITS;
    localparam int RES_W     = ACC_W - RND_SHIFT;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (RND_SHIFT - 1);

    localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    // cyclic neighbors for the cross products
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
        logic signed [ROT_W-1:0] rot_x;
        logic signed [ROT_W-1:0] rot_y;
        logic signed [ROT_W-1:0] rot_z;
        logic signed [ROT_W-1:0] rot_w;
    } t_qvr_in;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic signed [VEC_W-1:0] out_z;
        logic                    clipped;
    } t_qvr_out;

endpackage

`default_nettype wire

### hw/rtl/qvr_finish.sv
// ----------------------------------------------------------------------------
// qvr_finish
// scales one exact sum back to the vector format and saturates it
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_finish
    import qvr_pkg::*;
(
    input  logic signed [ACC_W-1:0] i_acc,
    output logic signed [VEC_W-1:0] o_val,
    output logic                    o_clip
);

    logic signed [RES_W-1:0]  s_res;
    logic [RES_W-VEC_W:0]     s_top;

    // rounding half is already in the sum
    assign s_res = RES_W'(i_acc >>> RND_SHIFT);
    assign s_top = s_res[RES_W-1:VEC_W-1];

    always_comb begin
        if ((&s_top) || !(|s_top)) begin
            o_val  = s_res[VEC_W-1:0];
            o_clip = 1'b0;
        end else begin
            o_val  = s_res[RES_W-1] ? VEC_MIN : VEC_MAX;
            o_clip = 1'b1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// rotates a Q16.16 vector by a Q1.14 quaternion: v + 2*w*uv + 2*uuv
// ----------------------------------------------------------------------------
// an accepted request passes through every pipeline stage in order; o_valid is the last stage's valid bit
// throughput: one request per cycle while i_stall is low, set by the five-stage product pipeline
// each stage holds its request while the next one is full and stalled, so
// bubbles close up and nothing is dropped or repeated
// reset clears the stage valid bits only, the datapath registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_qvr_in  i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_qvr_out o_req
);

    // stage valid bits and per-stage load enables
    logic [4:0] r_vld;
    logic [4:0] adv;

    // input request split into component arrays
    logic signed [VEC_W-1:0]   s_v   [3];
    logic signed [ROT_W-1:0]   s_q   [3];

    // stage 1: uv = q.xyz x v
    logic signed [VEC_W-1:0]   r_v1  [3];
    logic signed [ROT_W-1:0]   r_q1  [3];
    logic signed [ROT_W-1:0]   r_w1;
    logic signed [U_W-1:0]     r_u1  [3];
    logic signed [U_W-1:0]     n_u1  [3];

    // stage 2: second-level products
    logic signed [VEC_W-1:0]   r_v2  [3];
    logic signed [PROD2_W-1:0] r_pa  [3];
    logic signed [PROD2_W-1:0] r_pb  [3];
    logic signed [PROD2_W-1:0] r_pw  [3];
    logic signed [PROD2_W-1:0] n_pa  [3];
    logic signed [PROD2_W-1:0] n_pb  [3];
    logic signed [PROD2_W-1:0] n_pw  [3];

    // stage 3: uuv and the scaled v + 2*w*uv partial
    logic signed [W_W-1:0]     r_w3  [3];
    logic signed [ACC_W-1:0]   r_a3  [3];
    logic signed [W_W-1:0]     n_w3  [3];
    logic signed [ACC_W-1:0]   n_a3  [3];

    // stage 4: full sum with the rounding half
    logic signed [ACC_W-1:0]   r_acc [3];
    logic signed [ACC_W-1:0]   n_acc [3];

    // stage 5: rounded, saturated result
    logic signed [VEC_W-1:0]   f_val [3];
    logic [2:0]                f_clip;
    t_qvr_out                  r_out;
    t_qvr_out                  n_out;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        adv[4] = !r_vld[4] || !i_stall;
        for (int k = 3; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[4];
    assign o_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < 5; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_v[0] = i_req.vec_x;
    assign s_v[1] = i_req.vec_y;
    assign s_v[2] = i_req.vec_z;
    assign s_q[0] = i_req.rot_x;
    assign s_q[1] = i_req.rot_y;
    assign s_q[2] = i_req.rot_z;

    // first cross product, each term a 16x32 product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u1[i] = U_W'(PROD1_W'(s_q[NXT[i]]) * PROD1_W'(s_v[PRV[i]]))
                    - U_W'(PROD1_W'(s_v[NXT[i]]) * PROD1_W'(s_q[PRV[i]]));
        end
    end

    // second cross product terms and w*uv, each a 16x49 product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pa[i] = PROD2_W'(r_q1[NXT[i]]) * PROD2_W'(r_u1[PRV[i]]);
            n_pb[i] = PROD2_W'(r_u1[NXT[i]]) * PROD2_W'(r_q1[PRV[i]]);
            n_pw[i] = PROD2_W'(r_w1) * PROD2_W'(r_u1[i]);
        end
    end

    // uuv, and v brought to the product scale 2^(2*ROT_FRAC_BITS) beyond its own
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_w3[i] = W_W'(r_pa[i]) - W_W'(r_pb[i]);
            n_a3[i] = (ACC_W'(r_v2[i]) <<< RND_SHIFT) + (ACC_W'(r_pw[i]) <<< 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = r_a3[i] + (ACC_W'(r_w3[i]) <<< 1) + RND_HALF;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_finish
        qvr_finish u_finish (
            .i_acc  (r_acc[g]),
            .o_val  (f_val[g]),
            .o_clip (f_clip[g])
        );
    end

    always_comb begin
        n_out.out_x   = f_val[0];
        n_out.out_y   = f_val[1];
        n_out.out_z   = f_val[2];
        n_out.clipped = |f_clip;
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_v1 <= s_v;
            r_q1 <= s_q;
            r_w1 <= i_req.rot_w;
            r_u1 <= n_u1;
        end
        if (adv[1]) begin
            r_v2 <= r_v1;
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_pw <= n_pw;
        end
        if (adv[2]) begin
            r_w3 <= n_w3;
            r_a3 <= n_a3;
        end
        if (adv[3]) begin
            r_acc <= n_acc;
        end
        if (adv[4]) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
